>>> design/top_left_intra_residual_mode_core_defines.svh
// assertion macros for the top/left intra residual core
`ifndef TOP_LEFT_INTRA_RESIDUAL_MODE_CORE_DEFINES_SVH
`define TOP_LEFT_INTRA_RESIDUAL_MODE_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define TLIRM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TLIRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tlirm_pkg.sv
// shared constants, types and helpers of the top/left intra residual core
package tlirm_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W    = 8;
  localparam int RES_W    = PIX_W + 1;
  localparam int SIZE_W   = 12;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int SUM_W    = 32;
  localparam int SQ_W     = 38;
  localparam int RSQ_W    = 2 * PIX_W;
  localparam int N_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SQ_LO_W  = SQ_W / 2;
  localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
  localparam int PROD_W   = N_W + SQ_LO_W;
  localparam int A_W      = N_W + SQ_W;
  localparam int B_W      = 2 * SUM_W - 1;
  localparam int ENERGY_W = 60;

  localparam int FIELDS_W = 3 * RES_W - 1 + 2 * ENERGY_W + 1;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [PIX_W-1:0] MID_PIXEL = PIX_W'(128);
  localparam logic [PIX_W-1:0] MAX_PIXEL = PIX_W'(255);

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // per-pixel part of a result word
  typedef struct packed {
    logic signed [RES_W-1:0] top_residual;
    logic signed [RES_W-1:0] left_residual;
    logic [PIX_W-1:0]        residual_byte;
    logic                    frame_end;
  } pix_res_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v,
                                                 logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> design/top_left_intra_residual_mode_core.sv
// top/left intra prediction residual core with frame energy analysis
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------
//  s_*     | in  | s_tvalid / s_tready | s_tdata: pixel
//  m_*     | out | m_tvalid / m_tready | m_tdata: residuals, energies; m_tlast
//  apb     | in  | psel penable pready | frame_width @0x0, frame_height @0x4
//
//  one pixel per clock sustained while m_tready is high; a word passes through
//  stages 1 to 5 of a five-stage pipeline set by the energy multiply/subtract
//  the line store read is registered and bypassed when a row is one pixel wide
//  a stalled output fills empty stages first; s_tready falls only when all
//  five stages hold a word and m_tready is low
//  rst clears counters, sums and stage valids; the line store is not cleared
`include "top_left_intra_residual_mode_core_defines.svh"

module top_left_intra_residual_mode_core (
  input  logic                                    clk,
  input  logic                                    rst,
  // apb configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [tlirm_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [tlirm_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [tlirm_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                    pready,
  // pixel stream
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [tlirm_pkg::PIX_W-1:0]             s_tdata,   // [7:0] pixel
  // result stream
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // [8:0] top_residual, [17:9] left_residual, [25:18] residual_byte,
  // [85:26] top_energy, [145:86] left_energy, [146] top_better, rest zero
  output logic [tlirm_pkg::TDATA_W-1:0]           m_tdata,
  output logic                                    m_tlast    // frame_end
);

  // configuration
  logic [tlirm_pkg::SIZE_W-1:0] frame_width;
  logic [tlirm_pkg::SIZE_W-1:0] frame_height;
  logic                         cfg_wr;
  tlirm_pkg::reg_idx_t          reg_idx;

  // frame state
  logic [tlirm_pkg::COL_W-1:0]  column_count;
  logic [tlirm_pkg::COL_W-1:0]  column_count_next;
  logic [tlirm_pkg::ROW_W-1:0]  row_count;
  logic [tlirm_pkg::PIX_W-1:0]  prev_pixel;
  logic signed [tlirm_pkg::SUM_W-1:0] top_sum;
  logic signed [tlirm_pkg::SUM_W-1:0] left_sum;
  logic [tlirm_pkg::SQ_W-1:0]   top_square_sum;
  logic [tlirm_pkg::SQ_W-1:0]   left_square_sum;

  // line store
  logic [tlirm_pkg::PIX_W-1:0]  row_store [tlirm_pkg::MAX_WIDTH];
  logic [tlirm_pkg::PIX_W-1:0]  above_rd;
  logic [tlirm_pkg::PIX_W-1:0]  byp_pix;
  logic                         byp_hit;

  // per-pixel datapath
  logic                         in_acc;
  logic [tlirm_pkg::SIZE_W-1:0] eff_w;
  logic [tlirm_pkg::SIZE_W-1:0] eff_h;
  logic [2*tlirm_pkg::SIZE_W-1:0] n_full;
  logic [tlirm_pkg::PIX_W-1:0]  above;
  logic [tlirm_pkg::PIX_W-1:0]  left;
  logic signed [tlirm_pkg::RES_W-1:0] rt;
  logic signed [tlirm_pkg::RES_W-1:0] rl;
  logic signed [tlirm_pkg::RES_W:0]   rb_wide;
  logic [tlirm_pkg::PIX_W-1:0]  rb;
  logic signed [2*tlirm_pkg::RES_W-1:0] rt_prod;
  logic signed [2*tlirm_pkg::RES_W-1:0] rl_prod;
  logic signed [tlirm_pkg::SUM_W-1:0] top_sum_next;
  logic signed [tlirm_pkg::SUM_W-1:0] left_sum_next;
  logic [tlirm_pkg::SQ_W-1:0]   top_square_sum_next;
  logic [tlirm_pkg::SQ_W-1:0]   left_square_sum_next;
  logic                         last_col;
  logic                         last_row;
  logic                         last_pix;

  // pipeline
  logic en1, en2, en3, en4, en5;
  logic s1_v, s2_v, s3_v, s4_v, s5_v;
  tlirm_pkg::pix_res_t s1_res, s2_res, s3_res, s4_res, s5_res;
  logic [tlirm_pkg::N_W-1:0]    s1_n;
  logic signed [tlirm_pkg::SUM_W-1:0] s1_tsum;
  logic signed [tlirm_pkg::SUM_W-1:0] s1_lsum;
  logic [tlirm_pkg::SQ_W-1:0]   s1_tsq;
  logic [tlirm_pkg::SQ_W-1:0]   s1_lsq;
  logic signed [2*tlirm_pkg::SUM_W-1:0] t_ss;
  logic signed [2*tlirm_pkg::SUM_W-1:0] l_ss;
  logic [tlirm_pkg::PROD_W-1:0] s2_tlo, s2_thi, s2_llo, s2_lhi;
  logic [tlirm_pkg::B_W-1:0]    s2_tb, s2_lb;
  logic [tlirm_pkg::A_W-1:0]    s3_ta, s3_la;
  logic [tlirm_pkg::B_W-1:0]    s3_tb, s3_lb;
  logic [tlirm_pkg::ENERGY_W-1:0] s4_te, s4_le;
  logic [tlirm_pkg::ENERGY_W-1:0] s5_te, s5_le;
  logic                         s5_tb;

  // n*sq - s*s clamped to the energy range
  function automatic logic [tlirm_pkg::ENERGY_W-1:0] energy_clamp(
    logic [tlirm_pkg::A_W-1:0] a,
    logic [tlirm_pkg::B_W-1:0] b
  );
    logic [tlirm_pkg::A_W-1:0]      d;
    logic [tlirm_pkg::ENERGY_W-1:0] r;
    d = a - b[tlirm_pkg::A_W-1:0];
    if ({{(tlirm_pkg::B_W-tlirm_pkg::A_W){1'b0}}, a} <= b) begin
      r = '0;
    end else if (d[tlirm_pkg::A_W-1]) begin
      r = '1;
    end else begin
      r = d[tlirm_pkg::ENERGY_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = tlirm_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= tlirm_pkg::SIZE_W'(tlirm_pkg::MAX_WIDTH);
      frame_height <= tlirm_pkg::SIZE_W'(tlirm_pkg::MAX_HEIGHT);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tlirm_pkg::REG_FRAME_WIDTH:  frame_width  <= pwdata[tlirm_pkg::SIZE_W-1:0];
        tlirm_pkg::REG_FRAME_HEIGHT: frame_height <= pwdata[tlirm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tlirm_pkg::REG_FRAME_WIDTH:
        prdata = {{(tlirm_pkg::APB_DATA_W-tlirm_pkg::SIZE_W){1'b0}}, frame_width};
      tlirm_pkg::REG_FRAME_HEIGHT:
        prdata = {{(tlirm_pkg::APB_DATA_W-tlirm_pkg::SIZE_W){1'b0}}, frame_height};
      default:
        prdata = '0;
    endcase
  end

  // ------------------------------------------------------- per-pixel logic
  assign in_acc = s_tvalid && s_tready;
  assign eff_w  = tlirm_pkg::eff_size(frame_width,
                                      tlirm_pkg::SIZE_W'(tlirm_pkg::MAX_WIDTH));
  assign eff_h  = tlirm_pkg::eff_size(frame_height,
                                      tlirm_pkg::SIZE_W'(tlirm_pkg::MAX_HEIGHT));
  assign n_full = eff_w * eff_h;

  assign above = (row_count == '0) ? tlirm_pkg::MID_PIXEL
               : (byp_hit ? byp_pix : above_rd);
  assign left  = (column_count == '0) ? tlirm_pkg::MID_PIXEL : prev_pixel;

  assign rt = $signed({1'b0, s_tdata}) - $signed({1'b0, above});
  assign rl = $signed({1'b0, s_tdata}) - $signed({1'b0, left});

  // top residual re-centred on mid grey and clamped to a byte
  assign rb_wide = {rt[tlirm_pkg::RES_W-1], rt} + $signed({2'b00, tlirm_pkg::MID_PIXEL});
  always_comb begin
    if (rb_wide < 0) begin
      rb = '0;
    end else if (rb_wide > $signed({2'b00, tlirm_pkg::MAX_PIXEL})) begin
      rb = tlirm_pkg::MAX_PIXEL;
    end else begin
      rb = rb_wide[tlirm_pkg::PIX_W-1:0];
    end
  end

  assign rt_prod = rt * rt;
  assign rl_prod = rl * rl;

  assign top_sum_next  = top_sum
    + {{(tlirm_pkg::SUM_W-tlirm_pkg::RES_W){rt[tlirm_pkg::RES_W-1]}}, rt};
  assign left_sum_next = left_sum
    + {{(tlirm_pkg::SUM_W-tlirm_pkg::RES_W){rl[tlirm_pkg::RES_W-1]}}, rl};
  assign top_square_sum_next  = top_square_sum
    + {{(tlirm_pkg::SQ_W-tlirm_pkg::RSQ_W){1'b0}}, rt_prod[tlirm_pkg::RSQ_W-1:0]};
  assign left_square_sum_next = left_square_sum
    + {{(tlirm_pkg::SQ_W-tlirm_pkg::RSQ_W){1'b0}}, rl_prod[tlirm_pkg::RSQ_W-1:0]};

  assign last_col = ({1'b0, column_count} + tlirm_pkg::SIZE_W'(1)) >= eff_w;
  assign last_row = ({1'b0, row_count} + tlirm_pkg::SIZE_W'(1)) >= eff_h;
  assign last_pix = last_col && last_row;

  always_comb begin
    if (in_acc && last_col) begin
      column_count_next = '0;
    end else if (in_acc) begin
      column_count_next = column_count + tlirm_pkg::COL_W'(1);
    end else begin
      column_count_next = column_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      prev_pixel      <= '0;
      top_sum         <= '0;
      left_sum        <= '0;
      top_square_sum  <= '0;
      left_square_sum <= '0;
    end else if (in_acc) begin
      column_count <= column_count_next;
      prev_pixel   <= s_tdata;
      if (last_pix) begin
        row_count       <= '0;
        top_sum         <= '0;
        left_sum        <= '0;
        top_square_sum  <= '0;
        left_square_sum <= '0;
      end else begin
        if (last_col) begin
          row_count <= row_count + tlirm_pkg::ROW_W'(1);
        end
        top_sum         <= top_sum_next;
        left_sum        <= left_sum_next;
        top_square_sum  <= top_square_sum_next;
        left_square_sum <= left_square_sum_next;
      end
    end
  end

  // line store: read ahead at the column the next pixel will use
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_store[column_count] <= s_tdata;
    end
    above_rd <= row_store[column_count_next];
    byp_pix  <= s_tdata;
  end

  // same column written and read at the same edge: take the new pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= in_acc && (column_count == column_count_next);
    end
  end

  // -------------------------------------------------------------- pipeline
  assign en5 = !s5_v || m_tready;
  assign en4 = !s4_v || en5;
  assign en3 = !s3_v || en4;
  assign en2 = !s2_v || en3;
  assign en1 = !s1_v || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      if (en1) s1_v <= s_tvalid;
      if (en2) s2_v <= s1_v;
      if (en3) s3_v <= s2_v;
      if (en4) s4_v <= s3_v;
      if (en5) s5_v <= s4_v;
    end
  end

  // stage 1: residuals and, on frame end, the closing sums
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res.top_residual  <= rt;
      s1_res.left_residual <= rl;
      s1_res.residual_byte <= rb;
      s1_res.frame_end     <= last_pix;
      s1_n    <= n_full[tlirm_pkg::N_W-1:0];
      s1_tsum <= last_pix ? top_sum_next : '0;
      s1_lsum <= last_pix ? left_sum_next : '0;
      s1_tsq  <= last_pix ? top_square_sum_next : '0;
      s1_lsq  <= last_pix ? left_square_sum_next : '0;
    end
  end

  assign t_ss = s1_tsum * s1_tsum;
  assign l_ss = s1_lsum * s1_lsum;

  // stage 2: n times square sum in two halves, sum squared
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_res <= s1_res;
      s2_tlo <= s1_n * s1_tsq[tlirm_pkg::SQ_LO_W-1:0];
      s2_thi <= s1_n * s1_tsq[tlirm_pkg::SQ_W-1:tlirm_pkg::SQ_LO_W];
      s2_llo <= s1_n * s1_lsq[tlirm_pkg::SQ_LO_W-1:0];
      s2_lhi <= s1_n * s1_lsq[tlirm_pkg::SQ_W-1:tlirm_pkg::SQ_LO_W];
      s2_tb  <= t_ss[tlirm_pkg::B_W-1:0];
      s2_lb  <= l_ss[tlirm_pkg::B_W-1:0];
    end
  end

  // stage 3: join the partial products
  always_ff @(posedge clk) begin
    if (en3) begin
      s3_res <= s2_res;
      s3_ta  <= {{(tlirm_pkg::A_W-tlirm_pkg::PROD_W){1'b0}}, s2_tlo}
              + {s2_thi, {tlirm_pkg::SQ_LO_W{1'b0}}};
      s3_la  <= {{(tlirm_pkg::A_W-tlirm_pkg::PROD_W){1'b0}}, s2_llo}
              + {s2_lhi, {tlirm_pkg::SQ_LO_W{1'b0}}};
      s3_tb  <= s2_tb;
      s3_lb  <= s2_lb;
    end
  end

  // stage 4: mean-removed energies
  always_ff @(posedge clk) begin
    if (en4) begin
      s4_res <= s3_res;
      s4_te  <= energy_clamp(s3_ta, s3_tb);
      s4_le  <= energy_clamp(s3_la, s3_lb);
    end
  end

  // stage 5: output word
  always_ff @(posedge clk) begin
    if (en5) begin
      s5_res <= s4_res;
      s5_te  <= s4_te;
      s5_le  <= s4_le;
      s5_tb  <= s4_te < s4_le;
    end
  end

  assign m_tvalid = s5_v;
  assign m_tlast  = s5_res.frame_end;
  assign m_tdata  = {{tlirm_pkg::PAD_W{1'b0}}, s5_tb, s5_le, s5_te,
                     s5_res.residual_byte, s5_res.left_residual,
                     s5_res.top_residual};

  // ------------------------------------------------------------ assertions
  `TLIRM_ASSERT_SAME(a_energy_only_at_end, s5_v && !s5_res.frame_end,
    s5_te == '0 && s5_le == '0 && !s5_tb, "energy fields set before frame end")
  `TLIRM_ASSERT_NEXT(a_frame_end_clears, in_acc && last_pix,
    column_count == '0 && row_count == '0 && top_sum == '0 &&
    left_square_sum == '0, "frame state not cleared after last pixel")
  `TLIRM_ASSERT_SAME(a_byte_half_matches_sign, s5_v,
    s5_res.residual_byte[tlirm_pkg::PIX_W-1] !=
    s5_res.top_residual[tlirm_pkg::RES_W-1], "residual byte on wrong side of mid grey")
  `TLIRM_ASSERT_SAME(a_stall_only_when_full, !s_tready,
    s1_v && s2_v && s3_v && s4_v && s5_v && !m_tready,
    "input stalled with a free pipeline stage")

endmodule
